>>> hdl/nrt_pkg.sv
package nrt_pkg;

    localparam int TABLE_SLOTS = 32;
    localparam int NAME_BYTES  = 16;
    localparam int IDX_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

    typedef enum logic [1:0] {
        OP_LOOKUP     = 2'd0,
        OP_REGISTER   = 2'd1,
        OP_UNREGISTER = 2'd2,
        OP_ENUMERATE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_INVALID  = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_NOTSUP   = 3'd3,
        ST_ALREADY  = 3'd4,
        ST_FULL     = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

    typedef struct packed {
        t_op         op;
        logic [31:0] dir;
        logic [63:0] nlo;
        logic [63:0] nhi;
        logic [31:0] ifc;
        logic [31:0] srv;
        logic [31:0] hnd;
        logic [7:0]  want;
        logic        wild;
        logic        empty;
    } t_req;

    typedef struct packed {
        logic             act;
        logic             seen;
        logic             done;
        logic             same;
        logic             free_found;
        logic [IDX_W-1:0] free_idx;
        logic [7:0]       count;
        logic [31:0]      srv;
        logic [31:0]      hnd;
        logic [63:0]      nlo;
        logic [63:0]      nhi;
    } t_tok;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
    } t_wr;

    function automatic logic [127:0] norm_name(input logic [127:0] raw);
        logic [127:0] r;
        logic         ended;
        r     = '0;
        ended = 1'b0;
        for (int i = 0; i < 16; i++) begin
            if (i >= NAME_BYTES || raw[i*8 +: 8] == 8'h00) begin
                ended = 1'b1;
            end
            if (!ended) begin
                r[i*8 +: 8] = raw[i*8 +: 8];
            end
        end
        return r;
    endfunction

endpackage

>>> hdl/nrt_cell.sv
module nrt_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [nrt_pkg::IDX_W-1:0] i_idx,
    input  nrt_pkg::t_req             i_req,
    input  nrt_pkg::t_wr              i_wr,
    input  nrt_pkg::t_tok             i_tok,
    output nrt_pkg::t_tok             o_tok
);

    logic [63:0] r_nlo;
    logic [63:0] r_nhi;
    logic [31:0] r_dir;
    logic [31:0] r_ifc;
    logic [31:0] r_srv;
    logic [31:0] r_hnd;
    nrt_pkg::t_tok r_tok;
    nrt_pkg::t_tok n_tok;

    logic eq_dir;
    logic eq_name;
    logic eq_ifc;
    logic ifc_ok;
    logic occupied;
    logic clr;

    assign eq_dir   = (r_dir == i_req.dir);
    assign eq_name  = (r_nlo == i_req.nlo) && (r_nhi == i_req.nhi);
    assign eq_ifc   = (r_ifc == i_req.ifc);
    assign ifc_ok   = i_req.wild || eq_ifc;
    assign occupied = (r_nlo[7:0] != 8'h00);

    always_comb begin
        n_tok = i_tok;
        clr   = 1'b0;
        unique case (i_req.op)
            nrt_pkg::OP_LOOKUP: begin
                if (!i_tok.done && eq_dir && eq_name) begin
                    n_tok.seen = 1'b1;
                    if (ifc_ok) begin
                        n_tok.done = 1'b1;
                        n_tok.srv  = r_srv;
                        n_tok.hnd  = r_hnd;
                    end
                end
            end
            nrt_pkg::OP_REGISTER: begin
                if (!i_tok.done && !i_req.empty && eq_dir && eq_name && eq_ifc) begin
                    n_tok.done = 1'b1;
                    n_tok.same = (r_srv == i_req.srv) && (r_hnd == i_req.hnd);
                end
                if (!i_tok.free_found && !occupied) begin
                    n_tok.free_found = 1'b1;
                    n_tok.free_idx   = i_idx;
                end
            end
            nrt_pkg::OP_UNREGISTER: begin
                if (!i_tok.done && eq_dir && eq_name && eq_ifc) begin
                    n_tok.done = 1'b1;
                    clr        = i_tok.act;
                end
            end
            nrt_pkg::OP_ENUMERATE: begin
                if (!i_tok.done && occupied && eq_dir && ifc_ok) begin
                    if (i_tok.count == i_req.want) begin
                        n_tok.done = 1'b1;
                        n_tok.srv  = r_srv;
                        n_tok.hnd  = r_hnd;
                        n_tok.nlo  = r_nlo;
                        n_tok.nhi  = r_nhi;
                    end else begin
                        n_tok.count = i_tok.count + 8'd1;
                    end
                end
            end
            default: begin
                n_tok = i_tok;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nlo <= '0;
            r_nhi <= '0;
            r_dir <= '0;
            r_ifc <= '0;
            r_srv <= '0;
            r_hnd <= '0;
        end else if (i_wr.en && i_wr.idx == i_idx) begin
            r_nlo <= i_req.nlo;
            r_nhi <= i_req.nhi;
            r_dir <= i_req.dir;
            r_ifc <= i_req.ifc;
            r_srv <= i_req.srv;
            r_hnd <= i_req.hnd;
        end else if (clr) begin
            r_nlo <= '0;
            r_nhi <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

>>> hdl/name_registry_table_top.sv
// Name registry table: TABLE_SLOTS registrations keyed by directory, a 16-byte
// zero-padded name and an interface id, all cleared at reset. Each request
// (lookup, register, unregister, enumerate) that passes the up-front checks
// walks a chain of slot cells, one slot per clock. The token leaving the last
// cell is registered, then the result enters the output register, and the
// next request is taken in the cycle after that. A request rejected up front
// (empty name on lookup, wildcard interface on register or unregister) skips
// the chain and goes on to the output register. One request is in flight at a time.
// The next one can be accepted while the previous result still waits in the
// output register. A request that reaches its end while that result still waits
// holds there until the output register frees. The wildcard interface id is
// written by any APB write, read back at address 0, and must only change while idle.
module name_registry_table_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_directory,
    input  logic [63:0] i_name_low,
    input  logic [63:0] i_name_high,
    input  logic [31:0] i_iface,
    input  logic [31:0] i_server,
    input  logic [31:0] i_handle,
    input  logic [7:0]  i_entry_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [31:0] o_server_out,
    output logic [31:0] o_handle_out,
    output logic [63:0] o_name_out_low,
    output logic [63:0] o_name_out_high,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [1:0] ADDR_WILD = 2'd0;

    nrt_pkg::t_state r_state;
    nrt_pkg::t_state n_state;
    nrt_pkg::t_req   r_req;
    nrt_pkg::t_req   n_req;
    nrt_pkg::t_tok   r_fin;
    nrt_pkg::t_tok   w_head;
    nrt_pkg::t_tok   w_tok [nrt_pkg::TABLE_SLOTS+1];
    nrt_pkg::t_wr    w_wr;
    logic [31:0]     r_wild;
    logic            r_start;
    logic            r_bad;
    logic            r_out_valid;
    nrt_pkg::t_status r_status;
    nrt_pkg::t_status n_status;
    logic [31:0]     r_srv_out;
    logic [31:0]     r_hnd_out;
    logic [63:0]     r_nlo_out;
    logic [63:0]     r_nhi_out;
    logic [127:0]    norm;
    logic            accept;
    logic            fin_go;
    logic            bad;
    logic            last_act;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_WILD) ? r_wild : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wild <= '0;
        end else if (psel && penable && pwrite) begin
            r_wild <= pwdata;
        end
    end

    always_comb begin
        norm        = nrt_pkg::norm_name({i_name_high, i_name_low});
        n_req.op    = nrt_pkg::t_op'(i_operation);
        n_req.dir   = i_directory;
        n_req.nlo   = norm[63:0];
        n_req.nhi   = norm[127:64];
        n_req.ifc   = i_iface;
        n_req.srv   = i_server;
        n_req.hnd   = i_handle;
        n_req.want  = i_entry_index;
        n_req.wild  = (i_iface == r_wild);
        n_req.empty = (norm[7:0] == 8'h00);
        bad = ((n_req.op == nrt_pkg::OP_LOOKUP) && n_req.empty) ||
              (((n_req.op == nrt_pkg::OP_REGISTER) || (n_req.op == nrt_pkg::OP_UNREGISTER))
               && n_req.wild);
    end

    assign last_act = w_tok[nrt_pkg::TABLE_SLOTS].act;

    always_comb begin
        o_ready = (r_state == nrt_pkg::S_IDLE);
        accept  = i_valid && o_ready;
        fin_go  = (r_state == nrt_pkg::S_FIN) && (!r_out_valid || i_ready);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nrt_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = bad ? nrt_pkg::S_FIN : nrt_pkg::S_SCAN;
                end
            end
            nrt_pkg::S_SCAN: begin
                if (last_act) begin
                    n_state = nrt_pkg::S_FIN;
                end
            end
            nrt_pkg::S_FIN: begin
                if (fin_go) begin
                    n_state = nrt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = nrt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nrt_pkg::S_IDLE;
            r_start <= 1'b0;
            r_bad   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= accept && !bad;
            if (accept) begin
                r_bad <= bad;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= n_req;
        end
        if (r_state == nrt_pkg::S_SCAN && last_act) begin
            r_fin <= w_tok[nrt_pkg::TABLE_SLOTS];
        end
    end

    always_comb begin
        w_head     = '0;
        w_head.act = r_start;
    end

    assign w_tok[0] = w_head;

    for (genvar s = 0; s < nrt_pkg::TABLE_SLOTS; s++) begin : g_cell
        nrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (nrt_pkg::IDX_W'(s)),
            .i_req   (r_req),
            .i_wr    (w_wr),
            .i_tok   (w_tok[s]),
            .o_tok   (w_tok[s+1])
        );
    end

    always_comb begin
        w_wr.en  = fin_go && !r_bad && (r_req.op == nrt_pkg::OP_REGISTER) &&
                   !r_fin.done && r_fin.free_found;
        w_wr.idx = r_fin.free_idx;
    end

    always_comb begin
        n_status = nrt_pkg::ST_OK;
        if (r_bad) begin
            n_status = nrt_pkg::ST_INVALID;
        end else begin
            unique case (r_req.op)
                nrt_pkg::OP_LOOKUP: begin
                    priority if (r_fin.done) begin
                        n_status = nrt_pkg::ST_OK;
                    end else if (r_fin.seen) begin
                        n_status = nrt_pkg::ST_NOTSUP;
                    end else begin
                        n_status = nrt_pkg::ST_NOTFOUND;
                    end
                end
                nrt_pkg::OP_REGISTER: begin
                    priority if (r_fin.done) begin
                        n_status = r_fin.same ? nrt_pkg::ST_OK : nrt_pkg::ST_ALREADY;
                    end else if (r_fin.free_found) begin
                        n_status = nrt_pkg::ST_OK;
                    end else begin
                        n_status = nrt_pkg::ST_FULL;
                    end
                end
                nrt_pkg::OP_UNREGISTER: begin
                    n_status = r_fin.done ? nrt_pkg::ST_OK : nrt_pkg::ST_NOTFOUND;
                end
                nrt_pkg::OP_ENUMERATE: begin
                    n_status = nrt_pkg::ST_OK;
                end
                default: begin
                    n_status = nrt_pkg::ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_go) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_go) begin
            r_status  <= n_status;
            r_srv_out <= r_bad ? 32'd0 : r_fin.srv;
            r_hnd_out <= r_bad ? 32'd0 : r_fin.hnd;
            r_nlo_out <= r_bad ? 64'd0 : r_fin.nlo;
            r_nhi_out <= r_bad ? 64'd0 : r_fin.nhi;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_server_out    = r_srv_out;
    assign o_handle_out    = r_hnd_out;
    assign o_name_out_low  = r_nlo_out;
    assign o_name_out_high = r_nhi_out;

endmodule

>>> hdl/nrt_checker.sv
module nrt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_status,
    input logic [31:0] o_server_out,
    input logic [63:0] o_name_out_low,
    input logic [63:0] o_name_out_high
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_status))
        else $error("status changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("new request taken while one is in progress");

    a_name_only_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != nrt_pkg::ST_OK) |->
            (o_name_out_low == 64'd0) && (o_name_out_high == 64'd0))
        else $error("name returned with a failing status");

    a_invalid_no_server: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == nrt_pkg::ST_INVALID) |-> (o_server_out == 32'd0))
        else $error("server returned for an invalid request");

endmodule

bind name_registry_table_top nrt_checker u_nrt_checker (.*);

>>> dv/tb_name_registry_table_top.sv
`default_nettype none

module tb_name_registry_table_top;
    timeunit 1ns;
    timeprecision 1ps;

    import nrt_pkg::*;

    localparam logic [1:0] WILDCARD_ADDR = 2'd0;

    typedef struct packed {
        t_op         op;
        logic [31:0] dir;
        logic [63:0] nlo;
        logic [63:0] nhi;
        logic [31:0] ifc;
        logic [31:0] srv;
        logic [31:0] hnd;
        logic [7:0]  idx;
    } request_t;

    typedef struct packed {
        t_status     status;
        logic [31:0] srv;
        logic [31:0] hnd;
        logic [63:0] nlo;
        logic [63:0] nhi;
    } reply_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_operation = '0;
    logic [31:0] i_directory = '0;
    logic [63:0] i_name_low = '0;
    logic [63:0] i_name_high = '0;
    logic [31:0] i_iface = '0;
    logic [31:0] i_server = '0;
    logic [31:0] i_handle = '0;
    logic [7:0]  i_entry_index = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_status;
    logic [31:0] o_server_out;
    logic [31:0] o_handle_out;
    logic [63:0] o_name_out_low;
    logic [63:0] o_name_out_high;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic [63:0] tbl_nlo [TABLE_SLOTS];
    logic [63:0] tbl_nhi [TABLE_SLOTS];
    logic [31:0] tbl_dir [TABLE_SLOTS];
    logic [31:0] tbl_ifc [TABLE_SLOTS];
    logic [31:0] tbl_srv [TABLE_SLOTS];
    logic [31:0] tbl_hnd [TABLE_SLOTS];
    logic [31:0] wildcard_now = '0;

    reply_t       pending_replies [$];
    logic [127:0] name_pool [8];
    int           name_len [8] = '{1, 2, 5, 8, 9, 12, 15, 16};
    logic [31:0]  dir_pool [4] = '{32'h0, 32'h1, 32'h8000_0000, 32'hFFFF_FFFF};

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_ask = 0;
    int hold_left = 0;
    int mismatch_count = 0;
    int reply_count = 0;
    int sent_count = 0;
    int status_seen [6] = '{default: 0};

    name_registry_table_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_operation    (i_operation),
        .i_directory    (i_directory),
        .i_name_low     (i_name_low),
        .i_name_high    (i_name_high),
        .i_iface        (i_iface),
        .i_server       (i_server),
        .i_handle       (i_handle),
        .i_entry_index  (i_entry_index),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_server_out   (o_server_out),
        .o_handle_out   (o_handle_out),
        .o_name_out_low (o_name_out_low),
        .o_name_out_high(o_name_out_high),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("Mismatches found");
        $finish;
    end

    function automatic logic [127:0] trim_name(logic [127:0] raw);
        logic [127:0] kept;
        int           len;
        kept = '0;
        len  = 0;
        while (len < NAME_BYTES && raw[len*8 +: 8] != 8'h00) len++;
        for (int b = 0; b < len; b++) kept[b*8 +: 8] = raw[b*8 +: 8];
        return kept;
    endfunction

    function automatic bit key_match(int s, logic [31:0] d, logic [63:0] lo, logic [63:0] hi);
        return tbl_dir[s] == d && tbl_nlo[s] == lo && tbl_nhi[s] == hi;
    endfunction

    function automatic reply_t registry_apply(request_t rq);
        reply_t      rp;
        logic [63:0] klo;
        logic [63:0] khi;
        bit          wild;
        bit          empty;
        bit          seen;
        bit          hit;
        int          dup;
        int          fr;
        int          count;
        rp = '0;
        rp.status = ST_OK;
        {khi, klo} = trim_name({rq.nhi, rq.nlo});
        wild  = (rq.ifc == wildcard_now);
        empty = (klo[7:0] == 8'h00);
        seen  = 1'b0;
        hit   = 1'b0;
        dup   = -1;
        fr    = -1;
        count = 0;
        case (rq.op)
            OP_LOOKUP: begin
                if (empty) begin
                    rp.status = ST_INVALID;
                end else begin
                    for (int s = 0; s < TABLE_SLOTS && !hit; s++) begin
                        if (key_match(s, rq.dir, klo, khi)) begin
                            seen = 1'b1;
                            if (wild || rq.ifc == tbl_ifc[s]) begin
                                hit    = 1'b1;
                                rp.srv = tbl_srv[s];
                                rp.hnd = tbl_hnd[s];
                            end
                        end
                    end
                    if (hit) rp.status = ST_OK;
                    else if (seen) rp.status = ST_NOTSUP;
                    else rp.status = ST_NOTFOUND;
                end
            end
            OP_REGISTER: begin
                if (wild) begin
                    rp.status = ST_INVALID;
                end else begin
                    if (!empty) begin
                        for (int s = 0; s < TABLE_SLOTS && dup < 0; s++) begin
                            if (key_match(s, rq.dir, klo, khi) && tbl_ifc[s] == rq.ifc) dup = s;
                        end
                    end
                    if (dup >= 0) begin
                        if (tbl_srv[dup] == rq.srv && tbl_hnd[dup] == rq.hnd) rp.status = ST_OK;
                        else rp.status = ST_ALREADY;
                    end else begin
                        for (int s = 0; s < TABLE_SLOTS && fr < 0; s++) begin
                            if (tbl_nlo[s][7:0] == 8'h00) fr = s;
                        end
                        if (fr < 0) begin
                            rp.status = ST_FULL;
                        end else begin
                            tbl_nlo[fr] = klo;
                            tbl_nhi[fr] = khi;
                            tbl_dir[fr] = rq.dir;
                            tbl_ifc[fr] = rq.ifc;
                            tbl_srv[fr] = rq.srv;
                            tbl_hnd[fr] = rq.hnd;
                        end
                    end
                end
            end
            OP_UNREGISTER: begin
                if (wild) begin
                    rp.status = ST_INVALID;
                end else begin
                    rp.status = ST_NOTFOUND;
                    for (int s = 0; s < TABLE_SLOTS && !hit; s++) begin
                        if (key_match(s, rq.dir, klo, khi) && tbl_ifc[s] == rq.ifc) begin
                            hit = 1'b1;
                            tbl_nlo[s] = '0;
                            tbl_nhi[s] = '0;
                            rp.status = ST_OK;
                        end
                    end
                end
            end
            default: begin
                for (int s = 0; s < TABLE_SLOTS && !hit; s++) begin
                    if (tbl_nlo[s][7:0] != 8'h00 && tbl_dir[s] == rq.dir &&
                        (wild || rq.ifc == tbl_ifc[s])) begin
                        if (count == rq.idx) begin
                            hit    = 1'b1;
                            rp.srv = tbl_srv[s];
                            rp.hnd = tbl_hnd[s];
                            rp.nlo = tbl_nlo[s];
                            rp.nhi = tbl_nhi[s];
                        end else begin
                            count++;
                        end
                    end
                end
            end
        endcase
        return rp;
    endfunction

    function automatic request_t mk(t_op op, logic [31:0] dir, logic [63:0] lo,
                                    logic [63:0] hi, logic [31:0] ifc, logic [31:0] srv,
                                    logic [31:0] hnd, logic [7:0] idx);
        request_t rq;
        rq.op  = op;
        rq.dir = dir;
        rq.nlo = lo;
        rq.nhi = hi;
        rq.ifc = ifc;
        rq.srv = srv;
        rq.hnd = hnd;
        rq.idx = idx;
        return rq;
    endfunction

    function automatic logic [127:0] spell_name(int len, bit tail);
        logic [127:0] raw;
        raw = '0;
        for (int b = 0; b < 16; b++) begin
            if (b < len) raw[b*8 +: 8] = 8'($urandom_range(1, 255));
            else if (tail && b > len) raw[b*8 +: 8] = 8'($urandom);
        end
        return raw;
    endfunction

    function automatic request_t make_request();
        request_t     rq;
        logic [127:0] nm;
        logic [31:0]  ifc_pool [4];
        int           pick;
        rq = '0;
        ifc_pool = '{32'h1, 32'h2, 32'h3, 32'hFFFF_FFFF};
        if ($urandom_range(99) < 12) begin
            rq.op  = t_op'($urandom_range(3));
            rq.dir = $urandom;
            rq.nlo = {$urandom, $urandom};
            rq.nhi = {$urandom, $urandom};
            rq.ifc = $urandom;
            rq.srv = $urandom;
            rq.hnd = $urandom;
            rq.idx = 8'($urandom);
            return rq;
        end
        pick = $urandom_range(99);
        if (pick < 30) rq.op = OP_LOOKUP;
        else if (pick < 62) rq.op = OP_REGISTER;
        else if (pick < 80) rq.op = OP_UNREGISTER;
        else rq.op = OP_ENUMERATE;
        rq.dir = dir_pool[$urandom_range(3)];
        if ($urandom_range(15) == 0) begin
            nm = spell_name(0, $urandom_range(1));
        end else begin
            pick = $urandom_range(7);
            nm = name_pool[pick];
            if ($urandom_range(3) == 0) begin
                for (int b = name_len[pick] + 1; b < 16; b++) nm[b*8 +: 8] = 8'($urandom);
            end
        end
        {rq.nhi, rq.nlo} = nm;
        if ($urandom_range(99) < 15) rq.ifc = wildcard_now;
        else rq.ifc = ifc_pool[$urandom_range(3)];
        rq.srv = $urandom_range(1, 2);
        rq.hnd = $urandom_range(1, 2);
        if ($urandom_range(9) == 0) rq.idx = 8'($urandom_range(255));
        else rq.idx = 8'($urandom_range(6));
        return rq;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] wanted);
        if (mismatch_count < 100) begin
            $display("reply %0d: %s got %h want %h", reply_count, what, got, wanted);
        end
        mismatch_count++;
    endtask

    task automatic check_reply();
        reply_t want;
        reply_count++;
        if (o_status < 3'd6) status_seen[o_status]++;
        if (pending_replies.size() == 0) begin
            report_mismatch("reply with no request pending", o_status, '0);
            return;
        end
        want = pending_replies.pop_front();
        if (o_status !== want.status) report_mismatch("status", o_status, want.status);
        if (o_server_out !== want.srv) report_mismatch("server_out", o_server_out, want.srv);
        if (o_handle_out !== want.hnd) report_mismatch("handle_out", o_handle_out, want.hnd);
        if (o_name_out_low !== want.nlo) report_mismatch("name_out_low", o_name_out_low, want.nlo);
        if (o_name_out_high !== want.nhi) begin
            report_mismatch("name_out_high", o_name_out_high, want.nhi);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) check_reply();
        if (hold_ask > 0) begin
            hold_left = hold_ask;
            hold_ask  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_request(request_t rq);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_operation   <= rq.op;
        i_directory   <= rq.dir;
        i_name_low    <= rq.nlo;
        i_name_high   <= rq.nhi;
        i_iface       <= rq.ifc;
        i_server      <= rq.srv;
        i_handle      <= rq.hnd;
        i_entry_index <= rq.idx;
        do @(posedge i_clk); while (!o_ready);
        pending_replies.push_back(registry_apply(rq));
        sent_count++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_check(logic [1:0] addr, logic [31:0] wanted);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== wanted) report_mismatch("wildcard readback", prdata, wanted);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_wildcard(logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= WILDCARD_ADDR;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        wildcard_now = value;
        @(posedge i_clk);
        apb_check(WILDCARD_ADDR, value);
    endtask

    task automatic test_rejects();
        send_request(mk(OP_LOOKUP, 32'h5, 64'hFFFF_FFFF_FFFF_FF00, '1, 32'h1, 0, 0, 0));
        send_request(mk(OP_REGISTER, 32'h5, 64'h41, 0, 32'h0, 32'h1, 32'h1, 0));
        send_request(mk(OP_UNREGISTER, 32'h5, 64'h41, 0, 32'h0, 0, 0, 0));
        wait_drained();
    endtask

    task automatic test_register_lookup();
        send_request(mk(OP_REGISTER, '1, '1, '1, 32'h1, '1, '1, 0));
        send_request(mk(OP_REGISTER, '1, '1, '1, 32'h1, '1, '1, 0));
        send_request(mk(OP_REGISTER, '1, '1, '1, 32'h1, '1, 32'h0, 0));
        send_request(mk(OP_LOOKUP, '1, '1, '1, 32'h1, 0, 0, 0));
        send_request(mk(OP_LOOKUP, '1, '1, '1, 32'h0, 0, 0, 0));
        send_request(mk(OP_LOOKUP, '1, '1, '1, 32'h2, 0, 0, 0));
        send_request(mk(OP_LOOKUP, 32'h0, '1, '1, 32'h1, 0, 0, 0));
        send_request(mk(OP_UNREGISTER, '1, '1, '1, 32'h1, 0, 0, 0));
        send_request(mk(OP_LOOKUP, '1, '1, '1, 32'h1, 0, 0, 0));
        send_request(mk(OP_UNREGISTER, '1, '1, '1, 32'h1, 0, 0, 0));
        wait_drained();
    endtask

    task automatic test_name_padding();
        send_request(mk(OP_REGISTER, 32'h7, 64'hDEAD_BEEF_0000_6261, '1, 32'h2, 32'hA, 32'hB, 0));
        send_request(mk(OP_LOOKUP, 32'h7, 64'h6261, 0, 32'h2, 0, 0, 0));
        send_request(mk(OP_ENUMERATE, 32'h7, 0, 0, 32'h2, 0, 0, 8'd0));
        wait_drained();
    endtask

    task automatic test_empty_name_slot();
        send_request(mk(OP_REGISTER, 32'h9, 64'h7700, 0, 32'h3, 32'h5, 32'h6, 0));
        send_request(mk(OP_UNREGISTER, 32'h9, 0, 0, 32'h3, 0, 0, 0));
        send_request(mk(OP_ENUMERATE, 32'h9, 0, 0, 32'h0, 0, 0, 8'd0));
        send_request(mk(OP_ENUMERATE, 32'h7, 0, 0, 32'h2, 0, 0, 8'd255));
        wait_drained();
    endtask

    task automatic test_wildcard_settings();
        set_wildcard(32'hFFFF_FFFF);
        send_request(mk(OP_REGISTER, 32'h1, 64'h78, 0, 32'h0, 32'h7, 32'h8, 0));
        send_request(mk(OP_LOOKUP, 32'h1, 64'h78, 0, 32'hFFFF_FFFF, 0, 0, 0));
        send_request(mk(OP_REGISTER, 32'h1, 64'h78, 0, 32'hFFFF_FFFF, 32'h7, 32'h8, 0));
        send_request(mk(OP_ENUMERATE, 32'h1, 0, 0, 32'hFFFF_FFFF, 0, 0, 8'd0));
        wait_drained();
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_ask = 300;
        repeat (12) send_request(make_request());
        wait_drained();
    endtask

    task automatic test_table_fill();
        request_t made [$];
        request_t rq;
        send_idle_pct  = 10;
        recv_stall_pct = 10;
        for (int k = 0; k < 40; k++) begin
            rq = mk(OP_REGISTER, dir_pool[$urandom_range(3)], 0, 0, 32'h10 + k % 3,
                    $urandom, $urandom, 0);
            {rq.nhi, rq.nlo} = spell_name($urandom_range(1, 16), $urandom_range(1));
            send_request(rq);
            made.push_back(rq);
        end
        for (int k = 0; k < 6; k++) begin
            send_request(mk(OP_ENUMERATE, dir_pool[k % 4], 0, 0, wildcard_now, 0, 0,
                            8'($urandom_range(12))));
        end
        made.shuffle();
        foreach (made[k]) begin
            rq = made[k];
            rq.op = OP_UNREGISTER;
            send_request(rq);
        end
        wait_drained();
    endtask

    task automatic test_random_traffic(int n, int send_pct, int recv_pct, logic [31:0] wc);
        wait_drained();
        set_wildcard(wc);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (n) send_request(make_request());
        wait_drained();
    endtask

    initial begin
        for (int s = 0; s < TABLE_SLOTS; s++) begin
            tbl_nlo[s] = '0;
            tbl_nhi[s] = '0;
            tbl_dir[s] = '0;
            tbl_ifc[s] = '0;
            tbl_srv[s] = '0;
            tbl_hnd[s] = '0;
        end
        foreach (name_pool[k]) name_pool[k] = spell_name(name_len[k], 1'b0);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        apb_check(WILDCARD_ADDR, '0);
        test_rejects();
        test_register_lookup();
        test_name_padding();
        test_empty_name_slot();
        test_wildcard_settings();
        test_backpressure();
        test_table_fill();
        test_random_traffic(205, 0, 0, 32'h2);
        test_random_traffic(205, 76, 0, 32'h0);
        test_random_traffic(205, 0, 76, 32'hFFFF_FFFF);
        test_random_traffic(205, 15, 15, $urandom);
        wait_drained();
        repeat (40) @(posedge i_clk);
        $display("Run covered %0d requests: directed cases, table fill and drain,", sent_count);
        $display("  long output stall, four idling mixes; ok %0d invalid %0d notfound %0d %s",
                 status_seen[0], status_seen[1], status_seen[2],
                 $sformatf("notsup %0d already %0d full %0d",
                           status_seen[3], status_seen[4], status_seen[5]));
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
hdl/nrt_pkg.sv
hdl/nrt_cell.sv
hdl/name_registry_table_top.sv
hdl/nrt_checker.sv
dv/tb_name_registry_table_top.sv
